>>> design/stereo_comb_allpass_reverb_macros.svh
// ----------------------------------------------------------------------------
// Reverb assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_COMB_ALLPASS_REVERB_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_MACROS_SVH

// Same-cycle implication.
`define SCR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define SCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/scar_pkg.sv
// ----------------------------------------------------------------------------
// scar_pkg
// Types, constants and tuning functions of the stereo comb/allpass reverb.
// ----------------------------------------------------------------------------
`default_nettype none

package scar_pkg;

	localparam int COMBS_PER_CHANNEL_DEF     = 8;
	localparam int ALLPASSES_PER_CHANNEL_DEF = 4;
	localparam int RIGHT_SPREAD_DEF          = 23;
	localparam int SAMPLE_BITS_DEF           = 32;

	localparam int DC_BIAS    = 3;
	localparam int CLEN_W     = 11;
	localparam int ALEN_W     = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int MUL_B_W    = 18;
	localparam int SUM_W      = 37;

	localparam logic [14:0] ROOM_RST = 15'd27525;
	localparam logic [14:0] DAMP_RST = 15'd6554;
	localparam logic [16:0] WETD_RST = 17'd98304;
	localparam logic [15:0] WETC_RST = 16'd0;
	localparam logic [15:0] GAIN_RST = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOM = 3'd0,
		CFG_DAMP = 3'd1,
		CFG_WETD = 3'd2,
		CFG_WETC = 3'd3,
		CFG_GAIN = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_IN, S_INW,
		S_CRD, S_CTAP, S_CLP, S_CFS, S_CWR,
		S_ARD, S_AWR,
		S_O1, S_O2, S_O3, S_O4, S_O5, S_FIN
	} state_t;

	function automatic logic [CLEN_W-1:0] comb_len(int i, logic ch, int spread);
		int t;
		case (i % 8)
			0: t = 1116;
			1: t = 1188;
			2: t = 1277;
			3: t = 1356;
			4: t = 1422;
			5: t = 1491;
			6: t = 1557;
			default: t = 1617;
		endcase
		return CLEN_W'(t + (ch ? spread : 0));
	endfunction

	function automatic logic [ALEN_W-1:0] ap_len(int i, logic ch, int spread);
		int t;
		case (i % 4)
			0: t = 556;
			1: t = 441;
			2: t = 341;
			default: t = 225;
		endcase
		return ALEN_W'(t + (ch ? spread : 0));
	endfunction

	function automatic int comb_total(int n, int spread);
		int s;
		s = 0;
		for (int i = 0; i < n; i++) s += 2 * int'(comb_len(i, 1'b0, 0)) + spread;
		return s;
	endfunction

	function automatic int ap_total(int n, int spread);
		int s;
		s = 0;
		for (int i = 0; i < n; i++) s += 2 * int'(ap_len(i, 1'b0, 0)) + spread;
		return s;
	endfunction

endpackage

`default_nettype wire

>>> design/scar_ram.sv
// ----------------------------------------------------------------------------
// scar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> design/scar_qmul.sv
// ----------------------------------------------------------------------------
// scar_qmul
// Shared Q15 multiplier: full product, floor shift right by 15, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module scar_qmul #(
	parameter int SAMPLE_BITS = scar_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic signed [SAMPLE_BITS-1:0]          a,
	input  wire logic signed [scar_pkg::MUL_B_W-1:0]    b,
	output logic      signed [SAMPLE_BITS+2:0]          p
);

	localparam int PW = SAMPLE_BITS + scar_pkg::MUL_B_W;

	logic signed [PW-1:0] full;

	assign full = PW'(a) * PW'(b);

	always_ff @(posedge clk) begin
		p <= full[PW-1:15];
	end

endmodule

`default_nettype wire

>>> design/stereo_comb_allpass_reverb.sv
// Items are processed one at a time: the next item is taken only once the result has been
// loaded and the block has returned to the idle state; a stalled output holds the block longer.
// After reset both delay stores are filled with the bias value, one entry per cycle;
// no item is taken until that ends.
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Mono in, stereo out comb/allpass reverb, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_comb_allpass_reverb_macros.svh"

module stereo_comb_allpass_reverb #(
	parameter int COMBS_PER_CHANNEL     = scar_pkg::COMBS_PER_CHANNEL_DEF,
	parameter int ALLPASSES_PER_CHANNEL = scar_pkg::ALLPASSES_PER_CHANNEL_DEF,
	parameter int RIGHT_SPREAD          = scar_pkg::RIGHT_SPREAD_DEF,
	parameter int SAMPLE_BITS           = scar_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [scar_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [scar_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [15:0]                  sample_in,
	input  wire logic signed [31:0]                  mix_left_in,
	input  wire logic signed [31:0]                  mix_right_in,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [31:0]                       out_left,
	output logic signed [31:0]                       out_right
);

	localparam int N      = COMBS_PER_CHANNEL;
	localparam int A      = ALLPASSES_PER_CHANNEL;
	localparam int SB     = SAMPLE_BITS;
	localparam int CDEPTH = scar_pkg::comb_total(N, RIGHT_SPREAD);
	localparam int ADEPTH = scar_pkg::ap_total(A, RIGHT_SPREAD);
	localparam int CAW    = $clog2(CDEPTH);
	localparam int AAW    = $clog2(ADEPTH);
	localparam int CIW    = (N > 1) ? $clog2(N) : 1;
	localparam int AIW    = (A > 1) ? $clog2(A) : 1;
	localparam int CLW    = scar_pkg::CLEN_W;
	localparam int ALW    = scar_pkg::ALEN_W;
	localparam int BW     = scar_pkg::MUL_B_W;
	localparam int SW     = scar_pkg::SUM_W;

	scar_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [14:0] room_q, damp_q;
	logic [16:0] wetd_q;
	logic [15:0] wetc_q, gain_q;

	// Item registers.
	logic signed [15:0]    sample_q;
	logic signed [31:0]    mixl_q, mixr_q;
	logic signed [SB-1:0]  inp_q, acc_q, tap_q, t1_q, resl_q, resr_q;
	logic signed [SW-1:0]  suml_q, sumr_q;
	logic                  outv_q;
	logic signed [31:0]    outl_q, outr_q;

	// Filter state.
	logic signed [SB-1:0]  lp_q   [2][N];
	logic [CLW-1:0]        cpos_q [2][N];
	logic [ALW-1:0]        apos_q [2][A];

	// Sequencer counters.
	logic                  ch_q;
	logic [CIW-1:0]        cidx_q;
	logic [AIW-1:0]        aidx_q;
	logic [CAW-1:0]        cbase_q, caddr_q, clr_q;
	logic [AAW-1:0]        abase_q, aaddr_q;

	// Shared multiplier.
	logic signed [SB-1:0]  mul_a;
	logic signed [BW-1:0]  mul_b;
	logic signed [SB+2:0]  prod;
	logic signed [SB-1:0]  prod_lo;

	// Memory ports.
	logic                  c_we, a_we;
	logic [CAW-1:0]        c_waddr, c_raddr;
	logic [AAW-1:0]        a_waddr, a_raddr;
	logic [SB-1:0]         c_wdata, a_wdata, c_rdata, a_rdata;

	logic [CLW-1:0]        clen_cur, cpos_cur, cpos_nxt;
	logic [ALW-1:0]        alen_cur, apos_cur, apos_nxt;
	logic signed [SB-1:0]  fs, c_tap, a_tap, ap_out;
	logic                  c_last, a_last, fin_load, in_acc;

	assign prod_lo  = prod[SB-1:0];
	assign clen_cur = scar_pkg::comb_len(int'(cidx_q), ch_q, RIGHT_SPREAD);
	assign alen_cur = scar_pkg::ap_len(int'(aidx_q), ch_q, RIGHT_SPREAD);
	assign cpos_cur = cpos_q[ch_q][cidx_q];
	assign apos_cur = apos_q[ch_q][aidx_q];
	assign cpos_nxt = (cpos_cur + 1'b1 == clen_cur) ? '0 : cpos_cur + 1'b1;
	assign apos_nxt = (apos_cur + 1'b1 == alen_cur) ? '0 : apos_cur + 1'b1;
	assign c_last   = (cidx_q == CIW'(N - 1));
	assign a_last   = (aidx_q == AIW'(A - 1));
	assign c_tap    = signed'(c_rdata);
	assign a_tap    = signed'(a_rdata);
	assign fs       = t1_q + prod_lo;
	assign ap_out   = a_tap - acc_q;
	assign fin_load = (state_q == scar_pkg::S_FIN) && (!outv_q || out_ready);
	assign in_acc   = in_valid && in_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == scar_pkg::S_IDLE);
	assign out_valid = outv_q;
	assign out_left  = outl_q;
	assign out_right = outr_q;

	scar_qmul #(.SAMPLE_BITS(SB)) u_qmul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	scar_ram #(.WIDTH(SB), .DEPTH(CDEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	scar_ram #(.WIDTH(SB), .DEPTH(ADEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scar_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		c_we    = 1'b0;
		a_we    = 1'b0;
		c_waddr = caddr_q;
		a_waddr = aaddr_q;
		c_wdata = SB'(inp_q + prod_lo);
		a_wdata = SB'(acc_q + (a_tap >>> 1));
		c_raddr = CAW'(cbase_q + CAW'(cpos_cur));
		a_raddr = AAW'(abase_q + AAW'(apos_cur));
		case (state_q)
			scar_pkg::S_CLEAR: begin
				c_we    = 1'b1;
				a_we    = (int'(clr_q) < ADEPTH);
				c_waddr = clr_q;
				a_waddr = AAW'(clr_q);
				c_wdata = SB'(scar_pkg::DC_BIAS);
				a_wdata = SB'(scar_pkg::DC_BIAS);
				if (clr_q == CAW'(CDEPTH - 1)) state_d = scar_pkg::S_IDLE;
			end
			scar_pkg::S_IDLE: begin
				if (in_acc) state_d = scar_pkg::S_IN;
			end
			scar_pkg::S_IN: begin
				mul_a   = SB'(sample_q);
				mul_b   = signed'({1'b0, gain_q, 1'b0});
				state_d = scar_pkg::S_INW;
			end
			scar_pkg::S_INW: state_d = scar_pkg::S_CRD;
			scar_pkg::S_CRD: state_d = scar_pkg::S_CTAP;
			scar_pkg::S_CTAP: begin
				mul_a   = c_tap;
				mul_b   = signed'(BW'(32768) - BW'(damp_q));
				state_d = scar_pkg::S_CLP;
			end
			scar_pkg::S_CLP: begin
				mul_a   = lp_q[ch_q][cidx_q];
				mul_b   = signed'(BW'(damp_q));
				state_d = scar_pkg::S_CFS;
			end
			scar_pkg::S_CFS: begin
				mul_a   = fs;
				mul_b   = signed'(BW'(room_q));
				state_d = scar_pkg::S_CWR;
			end
			scar_pkg::S_CWR: begin
				c_we    = 1'b1;
				state_d = c_last ? scar_pkg::S_ARD : scar_pkg::S_CRD;
			end
			scar_pkg::S_ARD: state_d = scar_pkg::S_AWR;
			scar_pkg::S_AWR: begin
				a_we = 1'b1;
				if (a_last) begin
					state_d = ch_q ? scar_pkg::S_O1 : scar_pkg::S_CRD;
				end else begin
					state_d = scar_pkg::S_ARD;
				end
			end
			scar_pkg::S_O1: begin
				mul_a   = resl_q;
				mul_b   = signed'(BW'(wetd_q));
				state_d = scar_pkg::S_O2;
			end
			scar_pkg::S_O2: begin
				mul_a   = resr_q;
				mul_b   = signed'(BW'(wetc_q));
				state_d = scar_pkg::S_O3;
			end
			scar_pkg::S_O3: begin
				mul_a   = resr_q;
				mul_b   = signed'(BW'(wetd_q));
				state_d = scar_pkg::S_O4;
			end
			scar_pkg::S_O4: begin
				mul_a   = resl_q;
				mul_b   = signed'(BW'(wetc_q));
				state_d = scar_pkg::S_O5;
			end
			scar_pkg::S_O5: state_d = scar_pkg::S_FIN;
			scar_pkg::S_FIN: begin
				if (fin_load) state_d = scar_pkg::S_IDLE;
			end
			default: state_d = scar_pkg::S_IDLE;
		endcase
	end

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q <= scar_pkg::ROOM_RST;
			damp_q <= scar_pkg::DAMP_RST;
			wetd_q <= scar_pkg::WETD_RST;
			wetc_q <= scar_pkg::WETC_RST;
			gain_q <= scar_pkg::GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				scar_pkg::CFG_ROOM: room_q <= cfg_data[14:0];
				scar_pkg::CFG_DAMP: damp_q <= cfg_data[14:0];
				scar_pkg::CFG_WETD: wetd_q <= cfg_data[16:0];
				scar_pkg::CFG_WETC: wetc_q <= cfg_data[15:0];
				scar_pkg::CFG_GAIN: gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Control state: counters, positions, lowpass memory, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			ch_q    <= 1'b0;
			cidx_q  <= '0;
			aidx_q  <= '0;
			cbase_q <= '0;
			abase_q <= '0;
			outv_q  <= 1'b0;
			for (int c = 0; c < 2; c++) begin
				for (int i = 0; i < N; i++) begin
					lp_q[c][i]   <= '0;
					cpos_q[c][i] <= '0;
				end
				for (int i = 0; i < A; i++) apos_q[c][i] <= '0;
			end
		end else begin
			if (fin_load) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				scar_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				scar_pkg::S_IN: begin
					ch_q    <= 1'b0;
					cidx_q  <= '0;
					aidx_q  <= '0;
					cbase_q <= '0;
					abase_q <= '0;
				end
				scar_pkg::S_CFS: lp_q[ch_q][cidx_q] <= fs;
				scar_pkg::S_CWR: begin
					cpos_q[ch_q][cidx_q] <= cpos_nxt;
					cbase_q <= CAW'(cbase_q + CAW'(clen_cur));
					cidx_q  <= c_last ? '0 : cidx_q + 1'b1;
				end
				scar_pkg::S_AWR: begin
					apos_q[ch_q][aidx_q] <= apos_nxt;
					abase_q <= AAW'(abase_q + AAW'(alen_cur));
					aidx_q  <= a_last ? '0 : aidx_q + 1'b1;
					if (a_last) ch_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample_in;
			mixl_q   <= mix_left_in;
			mixr_q   <= mix_right_in;
		end
		case (state_q)
			scar_pkg::S_INW: begin
				inp_q <= SB'(prod_lo + SB'(scar_pkg::DC_BIAS));
				acc_q <= '0;
			end
			scar_pkg::S_CRD: caddr_q <= c_raddr;
			scar_pkg::S_CTAP: tap_q <= c_tap;
			scar_pkg::S_CFS: t1_q <= prod_lo;
			scar_pkg::S_CLP: t1_q <= prod_lo;
			scar_pkg::S_CWR: acc_q <= acc_q + tap_q;
			scar_pkg::S_ARD: aaddr_q <= a_raddr;
			scar_pkg::S_AWR: begin
				if (a_last && !ch_q) begin
					resl_q <= ap_out - SB'(scar_pkg::DC_BIAS);
					acc_q  <= '0;
				end else if (a_last) begin
					resr_q <= ap_out - SB'(scar_pkg::DC_BIAS);
				end else begin
					acc_q  <= ap_out;
				end
			end
			scar_pkg::S_O2: suml_q <= SW'(mixl_q) + SW'(prod);
			scar_pkg::S_O3: suml_q <= suml_q + SW'(prod);
			scar_pkg::S_O4: sumr_q <= SW'(mixr_q) + SW'(prod);
			scar_pkg::S_O5: sumr_q <= sumr_q + SW'(prod);
			default: ;
		endcase
		if (fin_load) begin
			outl_q <= (suml_q[SW-1:31] == '0 || suml_q[SW-1:31] == '1) ? suml_q[31:0]
				: (suml_q[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
			outr_q <= (sumr_q[SW-1:31] == '0 || sumr_q[SW-1:31] == '1) ? sumr_q[31:0]
				: (sumr_q[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		end
	end

	`SCR_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == scar_pkg::S_IN)
	`SCR_ASSERT_IMP(a_cpos_bound, state_q == scar_pkg::S_CRD, cpos_cur < clen_cur)
	`SCR_ASSERT_IMP(a_apos_bound, state_q == scar_pkg::S_ARD, apos_cur < alen_cur)
	`SCR_ASSERT_NEXT(a_fin_holds, (state_q == scar_pkg::S_FIN) && outv_q && !out_ready,
		state_q == scar_pkg::S_FIN)

endmodule

`default_nettype wire
